// ===== hdl/ovle_pkg.sv =====
// Package with the transaction types, opcodes and status codes of the ordered value list engine.
`default_nettype none

package ovle_pkg;

    typedef logic [1:0] opcode_t;
    typedef logic [2:0] status_t;

    localparam opcode_t OP_INSERT = 2'd0;
    localparam opcode_t OP_DELETE = 2'd1;
    localparam opcode_t OP_SEARCH = 2'd2;

    localparam status_t ST_INSERTED  = 3'd0;
    localparam status_t ST_FULL      = 3'd1;
    localparam status_t ST_DELETED   = 3'd2;
    localparam status_t ST_FOUND     = 3'd3;
    localparam status_t ST_NOT_FOUND = 3'd4;
    localparam status_t ST_EMPTY     = 3'd5;

    typedef struct packed {
        opcode_t            opcode;
        logic signed [31:0] value;
    } req_t;

    typedef struct packed {
        status_t    status;
        logic [4:0] position;
        logic [4:0] count;
    } rsp_t;

    typedef struct packed {
        logic capture;
        logic do_insert;
        logic do_delete;
    } cell_ctrl_t;

endpackage

`default_nettype wire

// ===== hdl/ovle_cell.sv =====
// One list cell: holds an entry, compares it with a request, loads an inserted value and shifts towards the head.
`default_nettype none

module ovle_cell
    import ovle_pkg::*;
#(
    parameter int INDEX = 0,
    parameter int CW    = 5
)
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire cell_ctrl_t         ctrl,
    input  wire logic [CW-1:0]      count,
    input  wire logic signed [31:0] probe,
    input  wire logic signed [31:0] write_value,
    input  wire logic signed [31:0] neighbour_entry,
    input  wire logic               seen_in,
    output logic signed [31:0]      entry,
    output logic                    seen_out,
    output logic                    first
);

    localparam logic [CW-1:0] MY_INDEX = CW'(INDEX);

    logic signed [31:0] entry_reg;
    logic signed [31:0] entry_next;
    logic               match_reg;
    logic               match_next;
    logic               occupied;

    assign occupied = count > MY_INDEX;
    assign entry    = entry_reg;
    assign seen_out = seen_in | match_reg;
    assign first    = match_reg & ~seen_in;

    always_comb
    begin
        match_next = match_reg;
        if (ctrl.capture)
        begin
            match_next = occupied && (entry_reg == probe);
        end
    end

    always_comb
    begin
        entry_next = entry_reg;
        if (ctrl.do_insert && (count == MY_INDEX))
        begin
            entry_next = write_value;
        end
        else if (ctrl.do_delete && seen_out)
        begin
            entry_next = neighbour_entry;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            match_reg <= 1'b0;
        end
        else
        begin
            match_reg <= match_next;
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

endmodule

`default_nettype wire

// ===== hdl/ordered_value_list_engine.sv =====
// Top level of the ordered value list engine: request control, cell chain and result register.
// On acceptance every cell compares its entry with the request value. While the request
// then executes, the match flags ripple along the cell chain to find the first match, the
// cells shift or load, and the result register is written. A new request is refused while
// one executes or a result is stalled; it can be accepted in the cycle a result is taken.
// The list holds CAPACITY entries; position and count carry the low five bits.
`default_nettype none

module ordered_value_list_engine
    import ovle_pkg::*;
#(
    parameter int CAPACITY = 16
)
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic req_valid,
    output logic      req_stall,
    input  wire req_t req,
    output logic      rsp_valid,
    input  wire logic rsp_stall,
    output rsp_t      rsp
);

    localparam int CW = $clog2(CAPACITY + 1);
    localparam logic [CW-1:0] FULL_COUNT = CW'(CAPACITY);

    logic               exec_reg;
    logic               exec_next;
    opcode_t            op_reg;
    opcode_t            op_next;
    logic signed [31:0] value_reg;
    logic signed [31:0] value_next;
    logic [CW-1:0]      count_reg;
    logic [CW-1:0]      count_next;
    logic               rsp_valid_reg;
    logic               rsp_valid_next;
    rsp_t               rsp_reg;
    rsp_t               rsp_next;

    logic               accept;
    cell_ctrl_t         ctrl;
    logic signed [31:0] cell_entry [CAPACITY];
    logic               cell_seen  [CAPACITY+1];
    logic               cell_first [CAPACITY];
    logic [CW-1:0]      match_pos;
    logic               found;
    status_t            status;
    logic [CW+4:0]      pos_wide;
    logic [CW+4:0]      count_wide;

    assign req_stall = exec_reg | (rsp_valid_reg & rsp_stall);
    assign accept    = req_valid & ~req_stall;
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    assign ctrl.capture   = accept;
    assign ctrl.do_insert = exec_reg && (op_reg == OP_INSERT) && (count_reg != FULL_COUNT);
    assign ctrl.do_delete = exec_reg && (op_reg == OP_DELETE);

    assign cell_seen[0] = 1'b0;

    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        logic signed [31:0] neighbour;
        if (i == CAPACITY - 1)
        begin : g_last
            assign neighbour = cell_entry[i];
        end
        else
        begin : g_mid
            assign neighbour = cell_entry[i+1];
        end

        ovle_cell #(
            .INDEX (i),
            .CW    (CW)
        ) u_cell (
            .clk             (clk),
            .rst_n           (rst_n),
            .ctrl            (ctrl),
            .count           (count_reg),
            .probe           (req.value),
            .write_value     (value_reg),
            .neighbour_entry (neighbour),
            .seen_in         (cell_seen[i]),
            .entry           (cell_entry[i]),
            .seen_out        (cell_seen[i+1]),
            .first           (cell_first[i])
        );
    end

    assign found = cell_seen[CAPACITY];

    always_comb
    begin
        match_pos = '0;
        for (int i = 0; i < CAPACITY; i++)
        begin
            if (cell_first[i])
            begin
                match_pos = match_pos | CW'(i + 1);
            end
        end
    end

    always_comb
    begin
        count_next = count_reg;
        status     = ST_NOT_FOUND;
        pos_wide   = '0;
        case (op_reg)
            OP_INSERT:
            begin
                if (count_reg == FULL_COUNT)
                begin
                    status = ST_FULL;
                end
                else
                begin
                    status     = ST_INSERTED;
                    count_next = count_reg + CW'(1);
                end
            end
            OP_DELETE:
            begin
                if (count_reg == '0)
                begin
                    status = ST_EMPTY;
                end
                else if (found)
                begin
                    status     = ST_DELETED;
                    count_next = count_reg - CW'(1);
                end
            end
            default:
            begin
                if (found)
                begin
                    status   = ST_FOUND;
                    pos_wide = {5'd0, match_pos};
                end
            end
        endcase
        if (!exec_reg)
        begin
            count_next = count_reg;
        end
        count_wide = {5'd0, count_next};
    end

    always_comb
    begin
        exec_next      = accept;
        op_next        = accept ? req.opcode : op_reg;
        value_next     = accept ? req.value : value_reg;
        rsp_valid_next = rsp_valid_reg & rsp_stall;
        rsp_next       = rsp_reg;
        if (exec_reg)
        begin
            rsp_valid_next    = 1'b1;
            rsp_next.status   = status;
            rsp_next.position = pos_wide[4:0];
            rsp_next.count    = count_wide[4:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            exec_reg      <= 1'b0;
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            exec_reg      <= exec_next;
            count_reg     <= count_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg    <= op_next;
        value_reg <= value_next;
        rsp_reg   <= rsp_next;
    end

endmodule

`default_nettype wire

// ===== hdl/ovle_checker.sv =====
// Port-level checker of the ordered value list engine and its binding to the top level.
`default_nettype none

module ovle_checker
    import ovle_pkg::*;
#(
    parameter int CAPACITY = 16
)
(
    input wire logic clk,
    input wire logic rst_n,
    input wire logic req_valid,
    input wire logic req_stall,
    input wire req_t req,
    input wire logic rsp_valid,
    input wire logic rsp_stall,
    input wire rsp_t rsp
);

    localparam bit SMALL_LIST = CAPACITY < 32;

    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
        else $error("Stalled result transaction changed.");

    a_rsp_after_req: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && !req_stall |-> ##2 rsp_valid)
        else $error("Accepted transaction gave no result two cycles later.");

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> rsp.status <= ST_EMPTY)
        else $error("Result carries an unused status code.");

    a_position_found: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && SMALL_LIST |->
            ((rsp.status == ST_FOUND) == (rsp.position != 5'd0)))
        else $error("Position does not agree with the found status.");

endmodule

bind ordered_value_list_engine ovle_checker #(.CAPACITY(CAPACITY)) u_ovle_checker (.*);

`default_nettype wire

// ===== verif/ovle_tb_pkg.sv =====
// Testbench package: list depth, spare opcode and the scoreboard that predicts and checks results.
`timescale 1ns / 1ps

package ovle_tb_pkg;

    import ovle_pkg::*;

    localparam int      LIST_DEPTH = 16;
    localparam opcode_t OP_UNUSED  = 2'd3;

    class value_list_scoreboard;

        logic signed [31:0] held_values [LIST_DEPTH];
        int                 held_count;
        rsp_t               expected_rsps [$];
        int unsigned        fault_count;

        function new();
            held_count  = 0;
            fault_count = 0;
            for (int i = 0; i < LIST_DEPTH; i++)
            begin
                held_values[i] = '0;
            end
        endfunction

        function rsp_t list_outcome(req_t r);
            rsp_t res;
            int   hit;
            int   i;
            res = '0;
            hit = -1;
            for (i = 0; i < held_count; i++)
            begin
                if (hit < 0 && held_values[i] == r.value)
                begin
                    hit = i;
                end
            end
            case (r.opcode)
                OP_INSERT:
                begin
                    if (held_count >= LIST_DEPTH)
                    begin
                        res.status = ST_FULL;
                    end
                    else
                    begin
                        held_values[held_count] = r.value;
                        held_count++;
                        res.status = ST_INSERTED;
                    end
                end
                OP_DELETE:
                begin
                    if (held_count == 0)
                    begin
                        res.status = ST_EMPTY;
                    end
                    else if (hit < 0)
                    begin
                        res.status = ST_NOT_FOUND;
                    end
                    else
                    begin
                        for (i = hit; i + 1 < held_count; i++)
                        begin
                            held_values[i] = held_values[i + 1];
                        end
                        held_count--;
                        res.status = ST_DELETED;
                    end
                end
                default:
                begin
                    if (hit < 0)
                    begin
                        res.status = ST_NOT_FOUND;
                    end
                    else
                    begin
                        res.status   = ST_FOUND;
                        res.position = 5'(hit + 1);
                    end
                end
            endcase
            res.count = 5'(held_count);
            return res;
        endfunction

        function void note_request(req_t r);
            expected_rsps.push_back(list_outcome(r));
        endfunction

        function void check_response(rsp_t got);
            rsp_t want;
            if (expected_rsps.size() == 0)
            begin
                $error("unexpected result transaction: status %0d position %0d count %0d",
                       got.status, got.position, got.count);
                fault_count++;
                return;
            end
            want = expected_rsps.pop_front();
            if (got.status !== want.status)
            begin
                $error("status: expected %0d, actual %0d", want.status, got.status);
                fault_count++;
            end
            if (got.position !== want.position)
            begin
                $error("position: expected %0d, actual %0d", want.position, got.position);
                fault_count++;
            end
            if (got.count !== want.count)
            begin
                $error("count: expected %0d, actual %0d", want.count, got.count);
                fault_count++;
            end
        endfunction

        function int pending();
            return expected_rsps.size();
        endfunction

    endclass

endpackage

// ===== verif/ordered_value_list_engine_tb.sv =====
// Testbench for the ordered value list engine: directed and random requests checked by a scoreboard.
`timescale 1ns / 1ps

module ordered_value_list_engine_tb;

    import ovle_pkg::*;
    import ovle_tb_pkg::*;

    localparam int CYCLE_LIMIT = 200000;
    localparam int PHASES      = 5;
    localparam int PHASE_ITEMS = 130;

    localparam logic signed [31:0] VAL_MIN = 32'sh8000_0000;
    localparam logic signed [31:0] VAL_MAX = 32'sh7FFF_FFFF;

    logic clk;
    logic rst_n     = 1'b0;
    logic req_valid = 1'b0;
    logic req_stall;
    req_t req       = '0;
    logic rsp_valid;
    logic rsp_stall = 1'b0;
    rsp_t rsp;

    value_list_scoreboard sb = new();

    bit                 sender_idle   = 1'b1;
    bit                 receiver_idle = 1'b1;
    logic signed [31:0] value_pool [6];
    int                 cycles        = 0;

    ordered_value_list_engine #(.CAPACITY(LIST_DEPTH)) u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("*** FAILED ***");
        $finish;
    end

    initial
    begin
        int stall_left;
        stall_left = 0;
        forever
        begin
            @(posedge clk);
            if (rst_n === 1'b1 && rsp_valid === 1'b1 && rsp_stall == 1'b0)
            begin
                sb.check_response(rsp);
            end
            if (!receiver_idle)
            begin
                stall_left = 0;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
            end
            else if ($urandom_range(0, 9) == 0)
            begin
                stall_left = $urandom_range(1, 18);
            end
            rsp_stall <= (stall_left > 0);
        end
    end

    task automatic send_request(input req_t r);
        if (sender_idle && $urandom_range(0, 7) == 0)
        begin
            req_valid <= 1'b0;
            req       <= req_t'({$urandom, $urandom});
            repeat ($urandom_range(1, 18)) @(posedge clk);
        end
        req_valid <= 1'b1;
        req       <= r;
        do
        begin
            @(posedge clk);
        end
        while (req_stall !== 1'b0);
        sb.note_request(r);
    endtask

    task automatic send_op(input opcode_t op, input logic signed [31:0] v);
        req_t r;
        r.opcode = op;
        r.value  = v;
        send_request(r);
    endtask

    task automatic drain_results();
        req_valid <= 1'b0;
        do
        begin
            @(posedge clk);
        end
        while (sb.pending() > 0);
    endtask

    function automatic logic signed [31:0] pick_value();
        if ($urandom_range(0, 9) < 7)
        begin
            return value_pool[$urandom_range(0, 5)];
        end
        return $urandom;
    endfunction

    function automatic opcode_t pick_opcode(input int insert_pct);
        int p;
        p = $urandom_range(0, 99);
        if (p < insert_pct)
        begin
            return OP_INSERT;
        end
        if (p < insert_pct + (100 - insert_pct) / 2)
        begin
            return OP_DELETE;
        end
        if (p < 97)
        begin
            return OP_SEARCH;
        end
        return OP_UNUSED;
    endfunction

    initial
    begin
        int insert_pct [PHASES];
        bit phase_idle [PHASES];

        insert_pct = '{75, 25, 55, 90, 50};
        phase_idle = '{1'b1, 1'b1, 1'b0, 1'b1, 1'b0};

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_op(OP_SEARCH, VAL_MIN);
        send_op(OP_DELETE, 32'sd5);
        send_op(OP_INSERT, VAL_MIN);
        send_op(OP_INSERT, VAL_MAX);
        send_op(OP_INSERT, 32'sd0);
        send_op(OP_INSERT, -32'sd1);
        send_op(OP_INSERT, VAL_MAX);
        send_op(OP_SEARCH, VAL_MAX);
        send_op(OP_UNUSED, -32'sd1);
        send_op(OP_DELETE, VAL_MAX);
        send_op(OP_SEARCH, VAL_MAX);
        send_op(OP_DELETE, 32'sd12345);
        send_op(OP_SEARCH, 32'sd777);
        for (int i = 1; i <= 12; i++)
        begin
            send_op(OP_INSERT, 32'(i * 32'h1357_9BDF));
        end
        send_op(OP_INSERT, 32'sd99);
        send_op(OP_SEARCH, 32'(12 * 32'h1357_9BDF));
        send_op(OP_DELETE, -32'sd1);
        send_op(OP_DELETE, 32'(12 * 32'h1357_9BDF));
        send_op(OP_DELETE, VAL_MIN);
        drain_results();

        for (int ph = 0; ph < PHASES; ph++)
        begin
            sender_idle   = phase_idle[ph];
            receiver_idle = phase_idle[ph];
            value_pool[0] = VAL_MIN;
            value_pool[1] = VAL_MAX;
            for (int k = 2; k < 6; k++)
            begin
                value_pool[k] = ($urandom_range(0, 1) == 0) ? 32'($urandom_range(0, 15)) : $urandom;
            end
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                send_op(pick_opcode(insert_pct[ph]), pick_value());
            end
            drain_results();
        end

        repeat (8) @(posedge clk);
        if (sb.fault_count == 0 && sb.pending() == 0)
        begin
            $display("*** PASSED ***");
        end
        else
        begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
